>>> rtl/pcdt_pkg.sv
package pcdt_pkg;

    // field widths fixed by the interface
    localparam int unsigned REQ_W         = 3;
    localparam int unsigned DATA_W        = 32;
    localparam int unsigned MODE_W        = 2;
    localparam int unsigned PHASE_W       = 64;
    localparam int unsigned CFG_INDEX_W   = 1;

    // counter storage width: default and upper bound
    localparam int unsigned COUNT_WIDTH_DEF = 32;
    localparam int unsigned COUNT_WIDTH_MAX = 64;

    // one elapsed tick in 32.32 fixed point
    localparam logic [PHASE_W-1:0] ONE_TICK = 64'h0000_0001_0000_0000;

    // request codes
    typedef enum logic [REQ_W-1:0] {
        REQ_TICK      = 3'd0,
        REQ_SET_COUNT = 3'd1,
        REQ_RUN       = 3'd2,
        REQ_STOP      = 3'd3,
        REQ_SET_LIMIT = 3'd4,
        REQ_READ      = 3'd5
    } t_req;

    // timer run mode
    typedef enum logic [MODE_W-1:0] {
        MODE_STOPPED  = 2'd0,
        MODE_PERIODIC = 2'd1,
        MODE_ONESHOT  = 2'd2
    } t_mode;

    // configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_PERIOD_WHOLE    = 1'b0,
        CFG_PERIOD_FRACTION = 1'b1
    } t_cfg_index;

endpackage

>>> rtl/periodic_oneshot_countdown_timer.sv
// an accepted request's result is registered into the output register on acceptance
// throughput: one request per cycle unless the result channel stalls; the only loop is
//   the timer state itself (counter, limit, mode, phase), updated in the accept cycle by
//   one 64-bit phase compare/subtract and one counter decrement
// reset (i_rst_n low, synchronous): timer stopped, counter, limit, phase and period zero,
//   no result pending
module periodic_oneshot_countdown_timer #(
    parameter int unsigned COUNT_WIDTH = pcdt_pkg::COUNT_WIDTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // configuration write port
    input  logic                             i_cfg_we,
    input  logic [pcdt_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [pcdt_pkg::DATA_W-1:0]      i_cfg_data,
    // request channel
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [pcdt_pkg::REQ_W-1:0]       i_req_type,
    input  logic [pcdt_pkg::DATA_W-1:0]      i_value,
    input  logic                             i_reload_flag,
    input  logic                             i_oneshot_flag,
    // result channel
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [pcdt_pkg::DATA_W-1:0]      o_current_count,
    output logic                             o_expired,
    output logic [pcdt_pkg::MODE_W-1:0]      o_run_mode,
    output logic                             o_run_refused
);
    import pcdt_pkg::*;

    // timer state
    t_mode                  r_mode,  n_mode;
    logic [COUNT_WIDTH-1:0] r_count, n_count;
    logic [COUNT_WIDTH-1:0] r_limit, n_limit;
    logic [PHASE_W-1:0]     r_phase, n_phase;
    logic [DATA_W-1:0]      r_period_whole;
    logic [DATA_W-1:0]      r_period_frac;

    // result register
    logic                   r_out_valid;
    logic [DATA_W-1:0]      r_out_count;
    logic                   r_out_expired;
    t_mode                  r_out_mode;
    logic                   r_out_refused;

    logic                   in_fire;
    t_req                   req;
    logic [COUNT_WIDTH_MAX-1:0] value_ext;
    logic [COUNT_WIDTH-1:0] value_c;
    logic [COUNT_WIDTH_MAX-1:0] count_ext;
    logic [PHASE_W-1:0]     period;
    logic                   period_zero;
    logic                   running;
    logic                   phase_ge;
    logic [PHASE_W-1:0]     gap;
    logic                   step_due;
    logic [PHASE_W-1:0]     rest;
    logic [PHASE_W-1:0]     wrap_raw;
    logic [PHASE_W-1:0]     wrap_phase;
    logic [COUNT_WIDTH-1:0] count_dec;
    logic                   fired;
    logic                   refused;

    // handshake: a pending result never blocks a new request if it is being taken
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_fire    = i_in_valid && o_in_ready;
    assign req        = t_req'(i_req_type);

    // request value resized to the counter width
    assign value_ext = {{(COUNT_WIDTH_MAX - DATA_W){1'b0}}, i_value};
    assign value_c   = value_ext[COUNT_WIDTH-1:0];

    // period and phase arithmetic
    assign period      = {r_period_whole, r_period_frac};
    assign period_zero = (period == '0);
    assign running     = (r_mode != MODE_STOPPED);
    assign phase_ge    = (r_phase >= period);
    assign gap         = period - r_phase;
    assign step_due    = phase_ge || (gap <= ONE_TICK);
    assign rest        = phase_ge ? '0 : gap;
    assign wrap_raw    = ONE_TICK - rest;
    assign wrap_phase  = (wrap_raw >= period) ? '0 : wrap_raw;
    assign count_dec   = (r_count != '0) ? r_count - 1'b1 : r_count;

    // next timer state and result flags
    always_comb begin
        n_mode  = r_mode;
        n_count = r_count;
        n_limit = r_limit;
        n_phase = r_phase;
        fired   = 1'b0;
        refused = 1'b0;
        unique case (req)
            REQ_TICK: begin
                if (running) begin
                    if (period_zero) begin
                        n_mode = MODE_STOPPED;
                    end else if (step_due) begin
                        n_phase = wrap_phase;
                        n_count = count_dec;
                        if (count_dec == '0) begin
                            fired = 1'b1;
                            if (r_mode == MODE_ONESHOT) begin
                                n_mode = MODE_STOPPED;
                            end else begin
                                // periodic reload from the limit
                                n_count = r_limit;
                                if (r_limit == '0) begin
                                    n_mode = MODE_STOPPED;
                                end
                            end
                        end
                    end else begin
                        n_phase = r_phase + ONE_TICK;
                    end
                end
            end
            REQ_SET_COUNT: begin
                n_count = value_c;
                if (running) begin
                    n_phase = '0;
                    if (value_c == '0) begin
                        fired   = 1'b1;
                        n_count = r_limit;
                    end
                    if ((value_c == '0 && r_limit == '0) || period_zero) begin
                        n_mode = MODE_STOPPED;
                    end
                end
            end
            REQ_RUN: begin
                if (running || period_zero) begin
                    refused = 1'b1;
                end else begin
                    n_mode  = i_oneshot_flag ? MODE_ONESHOT : MODE_PERIODIC;
                    n_phase = '0;
                    if (r_count == '0) begin
                        fired   = 1'b1;
                        n_count = r_limit;
                        if (r_limit == '0) begin
                            n_mode = MODE_STOPPED;
                        end
                    end
                end
            end
            REQ_STOP: begin
                n_mode  = MODE_STOPPED;
                n_phase = '0;
            end
            REQ_SET_LIMIT: begin
                n_limit = value_c;
                if (i_reload_flag) begin
                    n_count = value_c;
                    if (running) begin
                        n_phase = '0;
                        // a zero reload fires and reloads zero, so it stops
                        if (value_c == '0 || period_zero) begin
                            n_mode = MODE_STOPPED;
                        end
                        if (value_c == '0) begin
                            fired = 1'b1;
                        end
                    end
                end
            end
            default: begin
                // read and unused codes change nothing
            end
        endcase
    end

    // timer state registers; a period write restarts the phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode         <= MODE_STOPPED;
            r_count        <= '0;
            r_limit        <= '0;
            r_phase        <= '0;
            r_period_whole <= '0;
            r_period_frac  <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_PERIOD_WHOLE: begin
                    r_period_whole <= i_cfg_data;
                    if (i_cfg_data == '0 && r_period_frac == '0) begin
                        r_mode <= MODE_STOPPED;
                    end
                end
                CFG_PERIOD_FRACTION: begin
                    r_period_frac <= i_cfg_data;
                    if (i_cfg_data == '0 && r_period_whole == '0) begin
                        r_mode <= MODE_STOPPED;
                    end
                end
                default: begin
                end
            endcase
            r_phase <= '0;
        end else if (in_fire) begin
            r_mode  <= n_mode;
            r_count <= n_count;
            r_limit <= n_limit;
            r_phase <= n_phase;
        end
    end

    // result valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_out_valid <= i_in_valid;
        end
    end

    // counter seen through the 32-bit result field
    always_comb begin
        count_ext                = '0;
        count_ext[COUNT_WIDTH-1:0] = n_count;
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_out_count   <= count_ext[DATA_W-1:0];
            r_out_expired <= fired;
            r_out_mode    <= n_mode;
            r_out_refused <= refused;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_current_count = r_out_count;
    assign o_expired       = r_out_expired;
    assign o_run_mode      = r_out_mode;
    assign o_run_refused   = r_out_refused;

`ifndef NO_ASSERTIONS
    // a running timer always has a non-zero period
    a_run_needs_period: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode != MODE_STOPPED) |-> !period_zero)
        else $error("timer running with zero period");

    // the phase stays below the period unless it is zero
    a_phase_below_period: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == '0) || (r_phase < period))
        else $error("phase accumulator at or above period");

    // a refused run never fires
    a_refused_no_fire: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_refused) |-> !r_out_expired)
        else $error("refused run reported a fire");

    // an accepted request always yields a result next cycle
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> r_out_valid)
        else $error("accepted request produced no result");
`endif

endmodule

>>> sim/tb_periodic_oneshot_countdown_timer.sv
module tb_periodic_oneshot_countdown_timer;
    timeunit 1ns;
    timeprecision 1ps;

    import pcdt_pkg::*;

    localparam int unsigned STALL_LIMIT = 1000;
    // request codes the block treats as a plain read
    localparam logic [REQ_W-1:0] REQ_SPARE_LO = 3'd6;
    localparam logic [REQ_W-1:0] REQ_SPARE_HI = 3'd7;

    typedef struct packed {
        logic [DATA_W-1:0] count;
        logic              expired;
        t_mode             mode;
        logic              refused;
    } timer_result_t;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_cfg_we;
    logic [CFG_INDEX_W-1:0] i_cfg_index;
    logic [DATA_W-1:0]      i_cfg_data;
    logic                   i_in_valid;
    logic                   o_in_ready;
    logic [REQ_W-1:0]       i_req_type;
    logic [DATA_W-1:0]      i_value;
    logic                   i_reload_flag;
    logic                   i_oneshot_flag;
    logic                   o_out_valid;
    logic                   i_out_ready;
    logic [DATA_W-1:0]      o_current_count;
    logic                   o_expired;
    logic [MODE_W-1:0]      o_run_mode;
    logic                   o_run_refused;

    // timer state as the testbench expects it
    t_mode              exp_mode;
    logic [DATA_W-1:0]  exp_count;
    logic [DATA_W-1:0]  exp_limit;
    logic [DATA_W-1:0]  exp_whole;
    logic [DATA_W-1:0]  exp_fraction;
    logic [PHASE_W-1:0] exp_phase;

    timer_result_t timer_results_due[$];

    int unsigned idle_pct;
    int unsigned ready_hold;
    int unsigned quiet_cycles;
    int unsigned errors;
    int unsigned n_requests;
    int unsigned n_checked;
    int unsigned n_fired;
    int unsigned n_refused;
    int unsigned n_cfg_writes;

    periodic_oneshot_countdown_timer dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_req_type      (i_req_type),
        .i_value         (i_value),
        .i_reload_flag   (i_reload_flag),
        .i_oneshot_flag  (i_oneshot_flag),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_current_count (o_current_count),
        .o_expired       (o_expired),
        .o_run_mode      (o_run_mode),
        .o_run_refused   (o_run_refused)
    );

    // 12 ns clock
    always #6 i_clk = ~i_clk;

    // idle length: mostly none, some short, a few long
    function automatic int unsigned pick_idle_length();
        if ($urandom_range(99) >= idle_pct) return 0;
        if ($urandom_range(9) == 0) return $urandom_range(40, 12);
        return $urandom_range(3, 1);
    endfunction

    // zero counter while running: fire, load the limit, stop on zero limit or period
    function automatic logic reload_from_limit();
        logic fired;
        fired = 1'b0;
        if (exp_count == '0) begin
            fired     = 1'b1;
            exp_count = exp_limit;
        end
        if (exp_count == '0 || {exp_whole, exp_fraction} == '0)
            exp_mode = MODE_STOPPED;
        return fired;
    endfunction

    // expected timer behaviour for one request
    function automatic timer_result_t predict_timer_step(input logic [REQ_W-1:0] req,
                                                         input logic [DATA_W-1:0] val,
                                                         input logic reload,
                                                         input logic oneshot);
        timer_result_t      res;
        logic [PHASE_W-1:0] period;
        logic [PHASE_W-1:0] rest;
        logic               fired;
        logic               refused;
        fired   = 1'b0;
        refused = 1'b0;
        period  = {exp_whole, exp_fraction};
        case (req)
            REQ_TICK: begin
                if (exp_mode != MODE_STOPPED) begin
                    if (period == '0) begin
                        exp_mode = MODE_STOPPED;
                    end else if (exp_phase >= period || period - exp_phase <= ONE_TICK) begin
                        // period elapsed within this tick: carry the remainder
                        rest      = (exp_phase >= period) ? '0 : period - exp_phase;
                        exp_phase = ONE_TICK - rest;
                        if (exp_phase >= period) exp_phase = '0;
                        if (exp_count != '0) exp_count = exp_count - 1'b1;
                        if (exp_count == '0) begin
                            fired = 1'b1;
                            if (exp_mode == MODE_ONESHOT) exp_mode = MODE_STOPPED;
                            else void'(reload_from_limit());
                        end
                    end else begin
                        exp_phase = exp_phase + ONE_TICK;
                    end
                end
            end
            REQ_SET_COUNT: begin
                exp_count = val;
                if (exp_mode != MODE_STOPPED) begin
                    exp_phase = '0;
                    fired     = reload_from_limit();
                end
            end
            REQ_RUN: begin
                if (exp_mode != MODE_STOPPED || period == '0) begin
                    refused = 1'b1;
                end else begin
                    exp_mode  = oneshot ? MODE_ONESHOT : MODE_PERIODIC;
                    exp_phase = '0;
                    fired     = reload_from_limit();
                end
            end
            REQ_STOP: begin
                exp_mode  = MODE_STOPPED;
                exp_phase = '0;
            end
            REQ_SET_LIMIT: begin
                exp_limit = val;
                if (reload) begin
                    exp_count = val;
                    if (exp_mode != MODE_STOPPED) begin
                        exp_phase = '0;
                        fired     = reload_from_limit();
                    end
                end
            end
            default: ;
        endcase
        res.count   = exp_count;
        res.expired = fired;
        res.mode    = exp_mode;
        res.refused = refused;
        return res;
    endfunction

    // period register write: phase restarts, a zero period stops the timer
    function automatic void apply_period_write(input t_cfg_index idx,
                                               input logic [DATA_W-1:0] data);
        if (idx == CFG_PERIOD_WHOLE) exp_whole = data;
        else exp_fraction = data;
        exp_phase = '0;
        if (exp_mode != MODE_STOPPED && {exp_whole, exp_fraction} == '0)
            exp_mode = MODE_STOPPED;
    endfunction

    function automatic void check_field(input string name, input logic [DATA_W-1:0] want,
                                        input logic [DATA_W-1:0] got);
        if (got !== want) begin
            errors++;
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
        end
    endfunction

    // one request on the input channel, prediction taken at acceptance
    task automatic send_request(input logic [REQ_W-1:0] req, input logic [DATA_W-1:0] val,
                                input logic reload, input logic oneshot);
        int unsigned gap;
        gap = pick_idle_length();
        repeat (gap) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_in_valid     <= 1'b1;
        i_req_type     <= req;
        i_value        <= val;
        i_reload_flag  <= reload;
        i_oneshot_flag <= oneshot;
        do @(posedge i_clk); while (!o_in_ready);
        timer_results_due.push_back(predict_timer_step(req, val, reload, oneshot));
        n_requests++;
    endtask

    // hold off requests until every outstanding result is back
    task automatic drain_results();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (timer_results_due.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_period_reg(input t_cfg_index idx, input logic [DATA_W-1:0] data);
        drain_results();
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        apply_period_write(idx, data);
        n_cfg_writes++;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic write_period(input logic [DATA_W-1:0] whole,
                                input logic [DATA_W-1:0] fraction);
        write_period_reg(CFG_PERIOD_WHOLE, whole);
        write_period_reg(CFG_PERIOD_FRACTION, fraction);
    endtask

    // stopped timer after reset: reads, idle ticks, refused run, spare codes
    task automatic test_stopped_timer();
        idle_pct = 20;
        send_request(REQ_READ, '0, 1'b0, 1'b0);
        send_request(REQ_TICK, '1, 1'b1, 1'b1);
        send_request(REQ_RUN, '0, 1'b0, 1'b0);
        send_request(REQ_SPARE_LO, '1, 1'b1, 1'b1);
        send_request(REQ_SPARE_HI, 32'h5a5a_a5a5, 1'b0, 1'b1);
    endtask

    // hand-picked corner cases: zero start, one-shot, reloads, period changes
    task automatic test_directed_cases();
        write_period(32'd1, '0);
        // zero count and zero limit: fires at once and stops
        send_request(REQ_RUN, '0, 1'b0, 1'b0);
        send_request(REQ_SET_LIMIT, 32'd2, 1'b0, 1'b0);
        // one-shot from zero: fires, loads limit, then counts down and stops
        send_request(REQ_RUN, '0, 1'b0, 1'b1);
        send_request(REQ_TICK, '0, 1'b0, 1'b0);
        send_request(REQ_TICK, '0, 1'b0, 1'b0);
        send_request(REQ_SET_LIMIT, '1, 1'b1, 1'b0);
        send_request(REQ_SET_COUNT, 32'd1, 1'b0, 1'b0);
        send_request(REQ_RUN, '0, 1'b0, 1'b0);
        // already running
        send_request(REQ_RUN, '0, 1'b0, 1'b1);
        // periodic fire reloads full-scale limit
        send_request(REQ_TICK, '0, 1'b0, 1'b0);
        send_request(REQ_SET_COUNT, '0, 1'b0, 1'b0);
        // reload with zero limit while running: fires and stops
        send_request(REQ_SET_LIMIT, '0, 1'b1, 1'b0);
        send_request(REQ_SET_LIMIT, 32'd3, 1'b1, 1'b0);
        // sub-tick period: every tick decrements
        write_period('0, 32'h8000_0000);
        send_request(REQ_RUN, '0, 1'b0, 1'b0);
        write_period_reg(CFG_PERIOD_FRACTION, 32'h4000_0000);
        send_request(REQ_TICK, '0, 1'b0, 1'b0);
        send_request(REQ_TICK, '0, 1'b0, 1'b0);
        send_request(REQ_STOP, '0, 1'b0, 1'b0);
        send_request(REQ_RUN, '0, 1'b0, 1'b0);
        // period written to zero while running stops the timer
        write_period_reg(CFG_PERIOD_FRACTION, '0);
        send_request(REQ_READ, '0, 1'b0, 1'b0);
        // full-scale period: ticks only accumulate phase
        write_period('1, '1);
        send_request(REQ_RUN, '0, 1'b0, 1'b1);
        send_request(REQ_TICK, '0, 1'b0, 1'b0);
        send_request(REQ_STOP, '0, 1'b0, 1'b0);
    endtask

    // random traffic under one period setting, mostly ticks with small counts
    task automatic test_random_period(input logic [DATA_W-1:0] whole,
                                      input logic [DATA_W-1:0] fraction,
                                      input int unsigned n_items, input int unsigned idle);
        int unsigned       roll;
        logic [DATA_W-1:0] val;
        idle_pct = idle;
        write_period(whole, fraction);
        repeat (n_items) begin
            val  = ($urandom_range(3) == 0) ? $urandom : $urandom_range(6);
            roll = $urandom_range(99);
            if (roll < 55)
                send_request(REQ_TICK, $urandom, 1'($urandom_range(1)),
                             1'($urandom_range(1)));
            else if (roll < 63)
                send_request(REQ_SET_COUNT, val, 1'($urandom_range(1)),
                             1'($urandom_range(1)));
            else if (roll < 73)
                send_request(REQ_RUN, $urandom, 1'($urandom_range(1)),
                             1'($urandom_range(1)));
            else if (roll < 79)
                send_request(REQ_STOP, $urandom, 1'($urandom_range(1)),
                             1'($urandom_range(1)));
            else if (roll < 89)
                send_request(REQ_SET_LIMIT, val, 1'($urandom_range(1)),
                             1'($urandom_range(1)));
            else if (roll < 96)
                send_request(REQ_READ, $urandom, 1'($urandom_range(1)),
                             1'($urandom_range(1)));
            else
                send_request(($urandom_range(1) != 0) ? REQ_SPARE_HI : REQ_SPARE_LO,
                             $urandom, 1'($urandom_range(1)), 1'($urandom_range(1)));
            if ($urandom_range(59) == 0) drain_results();
        end
    endtask

    // result channel back-pressure
    always @(negedge i_clk) begin
        if (ready_hold == 0) ready_hold = pick_idle_length();
        if (ready_hold != 0) begin
            i_out_ready <= 1'b0;
            ready_hold--;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // compare each returned result with the oldest prediction
    always @(posedge i_clk) begin : check_results
        timer_result_t want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (timer_results_due.size() == 0) begin
                errors++;
                $display("%0t: result with none expected, count 0x%0h", $time, o_current_count);
            end else begin
                want = timer_results_due.pop_front();
                check_field("current_count", want.count, o_current_count);
                check_field("expired", DATA_W'(want.expired), DATA_W'(o_expired));
                check_field("run_mode", DATA_W'(want.mode), DATA_W'(o_run_mode));
                check_field("run_refused", DATA_W'(want.refused), DATA_W'(o_run_refused));
                n_checked++;
                if (want.expired) n_fired++;
                if (want.refused) n_refused++;
            end
        end
    end

    // watchdog on cycles with no handshake on either channel
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) quiet_cycles = 0;
        else quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, quiet_cycles);
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        i_clk          = 1'b0;
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_index    = CFG_PERIOD_WHOLE;
        i_cfg_data     = '0;
        i_in_valid     = 1'b0;
        i_req_type     = REQ_READ;
        i_value        = '0;
        i_reload_flag  = 1'b0;
        i_oneshot_flag = 1'b0;
        i_out_ready    = 1'b0;
        exp_mode       = MODE_STOPPED;
        exp_count      = '0;
        exp_limit      = '0;
        exp_whole      = '0;
        exp_fraction   = '0;
        exp_phase      = '0;
        idle_pct       = 0;
        ready_hold     = 0;
        quiet_cycles   = 0;
        errors         = 0;
        n_requests     = 0;
        n_checked      = 0;
        n_fired        = 0;
        n_refused      = 0;
        n_cfg_writes   = 0;

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_stopped_timer();
        test_directed_cases();
        test_random_period(32'd1, '0, 125, 30);
        test_random_period('0, 32'h8000_0000, 125, 30);
        test_random_period(32'd2, $urandom, 125, 30);
        test_random_period(32'd1, 32'h4000_0000, 125, 0);
        test_random_period('0, $urandom, 125, 30);
        test_random_period('0, '0, 40, 30);
        test_random_period('1, '1, 40, 30);
        test_random_period(32'd3, 32'hc000_0000, 125, 30);
        test_random_period('0, 32'd1, 125, 30);

        drain_results();
        repeat (4) @(posedge i_clk);
        if (timer_results_due.size() != 0) begin
            errors++;
            $display("%0t: %0d results never arrived", $time, timer_results_due.size());
        end

        $display("covered %0d requests and %0d checked results, %0d fires, %0d refused runs",
                 n_requests, n_checked, n_fired, n_refused);
        $display("across %0d period writes from zero through sub-tick to full-scale periods",
                 n_cfg_writes);
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

>>> filelist.f
rtl/pcdt_pkg.sv
rtl/periodic_oneshot_countdown_timer.sv
sim/tb_periodic_oneshot_countdown_timer.sv
